// File: rtl/thermistor_adc_to_temperature_unit_defines.svh
// ----------------------------------------------------------------------------
// Thermistor converter assertion macros
// Shared concurrent assertion forms used by the thermistor converter RTL.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_UNIT_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TATU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TATU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tatu_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor converter package
// Widths, the falling converter-code table and the item passed front to back.
// ----------------------------------------------------------------------------
package tatu_pkg;

    localparam int ADC_W         = 12;
    localparam int TEMP_W        = 13;
    localparam int TABLE_ENTRIES = 39;
    localparam int FRACTION_BITS = 4;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TEMP_BASE_C   = -40;
    localparam int TEMP_STEP_C   = 5;
    localparam int STEP_Q        = TEMP_STEP_C << FRACTION_BITS;
    localparam int STEP_W        = $clog2(STEP_Q + 1);
    localparam int Q_W           = $clog2(STEP_Q);
    localparam int NUM_W         = ADC_W + STEP_W;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADC_W-1:0]         t_adc;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [1:0] {
        CLS_MID,
        CLS_COLD,
        CLS_HOT
    } t_class;

    typedef struct packed {
        t_class cls;
        t_idx   left;
        t_adc   adc;
    } t_item;

    localparam t_adc NTC_CODES [TABLE_ENTRIES] = '{
        12'd3890, 12'd3831, 12'd3758, 12'd3672, 12'd3570, 12'd3451, 12'd3315,
        12'd3164, 12'd2997, 12'd2819, 12'd2631, 12'd2438, 12'd2242, 12'd2048,
        12'd1859, 12'd1678, 12'd1508, 12'd1349, 12'd1203, 12'd1070, 12'd950,
        12'd842,  12'd746,  12'd661,  12'd586,  12'd519,  12'd461,  12'd409,
        12'd364,  12'd324,  12'd289,  12'd259,  12'd231,  12'd208,  12'd187,
        12'd168,  12'd152,  12'd137,  12'd124
    };

    // Temperature of a table entry in output units.
    function automatic t_temp entry_temp(input t_idx i);
        int t;
        t = (TEMP_BASE_C + TEMP_STEP_C * int'(i)) * (1 << FRACTION_BITS);
        return t_temp'(t);
    endfunction

    localparam t_temp T_COLD = entry_temp(t_idx'(0));
    localparam t_temp T_HOT  = entry_temp(t_idx'(TABLE_ENTRIES - 1));

endpackage

// File: rtl/thermistor_adc_to_temperature_unit.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature unit
// Takes one reading per cycle; busy stays low because the back end never stalls.
// An accepted reading passes the front end, the queue and the back-end divider to o_valid.
// Throughput: one item per cycle, set by the bit-per-stage divider pipeline.
// Synchronous active-low reset clears all valid bits and the queue pointers.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tatu_pkg::t_adc  i_adc_reading,
    output logic            o_valid,
    output tatu_pkg::t_temp o_temperature_q4,
    output logic            o_cold_clamped,
    output logic            o_hot_clamped
);
    import tatu_pkg::*;
    `include "thermistor_adc_to_temperature_unit_defines.svh"

    localparam int LATENCY = 5 + Q_W;

    logic           accept;
    logic           push;
    t_item          front_item;
    logic [1:0]     inflight;
    logic           q_valid;
    t_item          q_item;
    t_cnt           q_count;
    logic           take;
    logic [CNT_W:0] occupancy;

    // Items already inside the front end still need a queue slot.
    assign occupancy = {1'b0, q_count} + (CNT_W+1)'(inflight);
    assign busy      = (occupancy >= (CNT_W+1)'(QUEUE_DEPTH));
    assign accept    = start && !busy;

    tatu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_adc      (i_adc_reading),
        .o_push     (push),
        .o_item     (front_item),
        .o_inflight (inflight)
    );

    tatu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (take),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    tatu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_take  (take),
        .o_valid (o_valid),
        .o_temp  (o_temperature_q4),
        .o_cold  (o_cold_clamped),
        .o_hot   (o_hot_clamped)
    );

    `TATU_ASSERT_NOW(a_result_follows, i_clk, i_rst_n, accept, ##LATENCY o_valid,
        "accepted item did not produce a result on time")
    `TATU_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_valid,
        !(o_cold_clamped && o_hot_clamped), "both clamp flags set")
    `TATU_ASSERT_NOW(a_cold_value, i_clk, i_rst_n, o_valid && o_cold_clamped,
        o_temperature_q4 == T_COLD, "cold clamp with wrong temperature")
    `TATU_ASSERT_NOW(a_hot_value, i_clk, i_rst_n, o_valid && o_hot_clamped,
        o_temperature_q4 == T_HOT, "hot clamp with wrong temperature")

endmodule

// File: rtl/tatu_front.sv
// ----------------------------------------------------------------------------
// Thermistor converter front end
// Compares a reading against every table code and encodes the interval.
// ----------------------------------------------------------------------------
module tatu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tatu_pkg::t_adc i_adc,
    output logic          o_push,
    output tatu_pkg::t_item o_item,
    output logic [1:0]    o_inflight
);
    import tatu_pkg::*;

    logic                     r_s1_vld;
    logic [TABLE_ENTRIES-1:0] r_s1_le;
    logic                     r_s1_cold;
    t_adc                     r_s1_adc;
    logic [TABLE_ENTRIES-1:0] n_s1_le;

    logic  r_s2_vld;
    t_item r_s2_item;
    t_item n_s2_item;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_s1_le[i] = (i_adc <= NTC_CODES[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_le   <= n_s1_le;
        r_s1_cold <= (i_adc >= NTC_CODES[0]);
        r_s1_adc  <= i_adc;
    end

    // The compare vector is a run of ones from entry zero; its last one marks
    // the left end of the interval.
    always_comb begin
        t_idx left;
        left = '0;
        for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
            if (r_s1_le[i] && !r_s1_le[i+1]) begin
                left = left | t_idx'(i);
            end
        end
        n_s2_item.adc  = r_s1_adc;
        n_s2_item.left = left;
        if (r_s1_cold) begin
            n_s2_item.cls  = CLS_COLD;
            n_s2_item.left = '0;
        end else if (r_s1_le[TABLE_ENTRIES-1]) begin
            n_s2_item.cls  = CLS_HOT;
            n_s2_item.left = '0;
        end else begin
            n_s2_item.cls = CLS_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_item <= n_s2_item;
    end

    assign o_push     = r_s2_vld;
    assign o_item     = r_s2_item;
    assign o_inflight = {1'b0, r_s1_vld} + {1'b0, r_s2_vld};

endmodule

// File: rtl/tatu_queue.sv
// ----------------------------------------------------------------------------
// Thermistor converter item queue
// Small first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module tatu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tatu_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output tatu_pkg::t_item o_item,
    output tatu_pkg::t_cnt  o_count
);
    import tatu_pkg::*;
    `include "thermistor_adc_to_temperature_unit_defines.svh"

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    t_cnt             r_count;
    t_cnt             n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    `TATU_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, r_count == t_cnt'(QUEUE_DEPTH) && !i_pop,
        !i_push, "queue written while full")
    `TATU_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0,
        "queue read while empty")
    `TATU_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop,
        r_count == $past(r_count) + 1'b1, "queue count did not follow a write")

endmodule

// File: rtl/tatu_back.sv
// ----------------------------------------------------------------------------
// Thermistor converter back end
// Forms the interpolation fraction and divides it in a bit-per-stage pipeline.
// ----------------------------------------------------------------------------
module tatu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tatu_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_valid,
    output tatu_pkg::t_temp o_temp,
    output logic            o_cold,
    output logic            o_hot
);
    import tatu_pkg::*;

    localparam int DW = NUM_W + Q_W;

    // Stage zero holds the dividend setup; stage Q_W holds the full quotient.
    logic             r_vld  [Q_W+1];
    logic [NUM_W-1:0] r_rem  [Q_W+1];
    logic [Q_W-1:0]   r_q    [Q_W+1];
    t_adc             r_den  [Q_W+1];
    t_temp            r_base [Q_W+1];
    logic             r_cold [Q_W+1];
    logic             r_hot  [Q_W+1];

    logic             n_rem;
    t_adc             hi;
    t_adc             lo;
    t_adc             diff;
    logic [NUM_W-1:0] n_num;
    t_adc             n_den;
    t_temp            n_base;

    logic  r_out_vld;
    t_temp r_out_temp;
    logic  r_out_cold;
    logic  r_out_hot;

    assign o_take = i_valid;
    assign n_rem  = 1'b0;

    always_comb begin
        hi     = NTC_CODES[i_item.left];
        lo     = NTC_CODES[t_idx'(i_item.left + 1'b1)];
        diff   = hi - i_item.adc;
        n_num  = NUM_W'(diff) * NUM_W'(STEP_Q);
        n_den  = hi - lo;
        n_base = entry_temp(i_item.left);
        case (i_item.cls)
            CLS_COLD: begin
                n_num  = '0;
                n_den  = t_adc'(1);
                n_base = T_COLD;
            end
            CLS_HOT: begin
                n_num  = '0;
                n_den  = t_adc'(1);
                n_base = T_HOT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_num;
        r_q[0]    <= {Q_W{n_rem}};
        r_den[0]  <= n_den;
        r_base[0] <= n_base;
        r_cold[0] <= (i_item.cls == CLS_COLD);
        r_hot[0]  <= (i_item.cls == CLS_HOT);
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        logic [DW-1:0]    dsh;
        logic             fits;
        logic [NUM_W-1:0] rem_next;

        always_comb begin
            dsh      = DW'(r_den[s]) << (Q_W - 1 - s);
            fits     = (DW'(r_rem[s]) >= dsh);
            rem_next = fits ? NUM_W'(DW'(r_rem[s]) - dsh) : r_rem[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= rem_next;
            r_q[s+1]    <= {r_q[s][Q_W-2:0], fits};
            r_den[s+1]  <= r_den[s];
            r_base[s+1] <= r_base[s];
            r_cold[s+1] <= r_cold[s];
            r_hot[s+1]  <= r_hot[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_temp <= r_base[Q_W] + t_temp'({{(TEMP_W-Q_W){1'b0}}, r_q[Q_W]});
        r_out_cold <= r_cold[Q_W];
        r_out_hot  <= r_hot[Q_W];
    end

    assign o_valid = r_out_vld;
    assign o_temp  = r_out_temp;
    assign o_cold  = r_out_cold;
    assign o_hot   = r_out_hot;

endmodule

// File: tb/sv/thermistor_adc_to_temperature_unit_tb.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature unit testbench
// Drives converter readings through the start/busy command port and checks
// every strobed temperature and clamp flag against an independent
// table-lookup and interpolation predictor, in order, field by field.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tatu_pkg::*;

    localparam int NUM_CODES      = 39;
    localparam int Q_SCALE        = 16;
    localparam int STEP_DEG       = 5;
    localparam int BASE_DEG       = -40;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int QUIET_ITEMS    = 300;
    localparam int DRAIN_AT_ITEM  = 900;
    localparam int LATENCY_CYCLES = 12;
    localparam int STALL_LIMIT    = 500;

    // Converter codes at each 5-degree step, falling from -40 C to 150 C.
    localparam int CODE_AT_STEP [NUM_CODES] = '{
        3890, 3831, 3758, 3672, 3570, 3451, 3315, 3164, 2997, 2819,
        2631, 2438, 2242, 2048, 1859, 1678, 1508, 1349, 1203, 1070,
        950,  842,  746,  661,  586,  519,  461,  409,  364,  324,
        289,  259,  231,  208,  187,  168,  152,  137,  124
    };

    typedef struct {
        t_temp temp;
        logic  cold;
        logic  hot;
    } t_temp_reading;

    function automatic t_temp_reading predict_temperature(input t_adc adc);
        t_temp_reading r;
        int            right;
        int            hi;
        int            lo;
        int            t;
        r.cold = 1'b0;
        r.hot  = 1'b0;
        if (int'(adc) >= CODE_AT_STEP[0]) begin
            t      = BASE_DEG * Q_SCALE;
            r.cold = 1'b1;
        end else if (int'(adc) <= CODE_AT_STEP[NUM_CODES-1]) begin
            t     = (BASE_DEG + STEP_DEG * (NUM_CODES - 1)) * Q_SCALE;
            r.hot = 1'b1;
        end else begin
            right = 1;
            while (right < NUM_CODES - 1 && CODE_AT_STEP[right] >= int'(adc))
                right++;
            hi = CODE_AT_STEP[right-1];
            lo = CODE_AT_STEP[right];
            // Both operands are non-negative, so integer division floors.
            t = (BASE_DEG + STEP_DEG * (right - 1)) * Q_SCALE
                + (STEP_DEG * Q_SCALE * (hi - int'(adc))) / (hi - lo);
        end
        r.temp = t_temp'(t);
        return r;
    endfunction

    class temp_scoreboard;
        t_temp_reading pending_temps [$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function void note_reading(input t_adc adc);
            pending_temps.push_back(predict_temperature(adc));
        endfunction

        function int waiting();
            return pending_temps.size();
        endfunction

        function void check_result(input t_temp temp, input logic cold, input logic hot);
            t_temp_reading exp_r;
            if (pending_temps.size() == 0) begin
                $display("%0t: unexpected result temp=%0d cold=%b hot=%b",
                         $time, temp, cold, hot);
                errors++;
                return;
            end
            exp_r = pending_temps.pop_front();
            if (temp !== exp_r.temp) begin
                $display("%0t: temperature_q4 expected %0d actual %0d",
                         $time, exp_r.temp, temp);
                errors++;
            end
            if (cold !== exp_r.cold) begin
                $display("%0t: cold_clamped expected %b actual %b", $time, exp_r.cold, cold);
                errors++;
            end
            if (hot !== exp_r.hot) begin
                $display("%0t: hot_clamped expected %b actual %b", $time, exp_r.hot, hot);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_adc  i_adc_reading = '0;
    logic  o_valid;
    t_temp o_temperature_q4;
    logic  o_cold_clamped;
    logic  o_hot_clamped;

    temp_scoreboard sb = new();
    int             stall_cycles = 0;

    thermistor_adc_to_temperature_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_adc_reading    (i_adc_reading),
        .o_valid          (o_valid),
        .o_temperature_q4 (o_temperature_q4),
        .o_cold_clamped   (o_cold_clamped),
        .o_hot_clamped    (o_hot_clamped)
    );

    always #2 i_clk = ~i_clk;

    // Values read here are the ones present at the edge, before any update.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_reading(i_adc_reading);
            if (o_valid)
                sb.check_result(o_temperature_q4, o_cold_clamped, o_hot_clamped);
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("** thermistor_adc_to_temperature_unit: FAILED **");
                $finish;
            end
        end
    end

    // Called right after a rising edge; returns once the item has been taken.
    task automatic send_reading(input t_adc adc);
        start         <= 1'b1;
        i_adc_reading <= adc;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic idle_for(input int cycles);
        start         <= 1'b0;
        i_adc_reading <= t_adc'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_adc random_reading();
        int pick;
        int idx;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            v = $urandom_range(CODE_AT_STEP[NUM_CODES-1] + 1, CODE_AT_STEP[0] - 1);
        end else if (pick < 85) begin
            // Land on or within two codes of a table code to hit interval edges.
            idx = $urandom_range(0, NUM_CODES - 1);
            v   = CODE_AT_STEP[idx] + $urandom_range(0, 4) - 2;
        end else begin
            v = $urandom_range(0, 4095);
        end
        return t_adc'(v);
    endfunction

    initial begin
        t_adc directed [$];
        int   idle_pct;
        directed = '{12'd0, 12'd4095, 12'd3890, 12'd3891, 12'd3889, 12'd3831,
                     12'd3832, 12'd2048, 12'd2049, 12'd1859, 12'd208, 12'd209,
                     12'd124, 12'd125, 12'd123, 12'd1, 12'd4094, 12'd2730,
                     12'd1365, 12'd3000, 12'd130, 12'd2047};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_reading(directed[k]);
        wait_drained();
        @(posedge i_clk);

        idle_pct = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Vary the sender's gap density in blocks, including no gaps at all.
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 40;
                endcase
            end
            if (n == DRAIN_AT_ITEM) begin
                wait_drained();
                @(posedge i_clk);
            end
            if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 99) < idle_pct)
                idle_for($urandom_range(1, 14));
            send_reading(random_reading());
        end

        wait_drained();
        repeat (LATENCY_CYCLES + 8) @(posedge i_clk);

        if (sb.errors == 0 && sb.waiting() == 0)
            $display("** thermistor_adc_to_temperature_unit: PASSED **");
        else
            $display("** thermistor_adc_to_temperature_unit: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tatu_pkg.sv
rtl/tatu_front.sv
rtl/tatu_queue.sv
rtl/tatu_back.sv
rtl/thermistor_adc_to_temperature_unit.sv
tb/sv/thermistor_adc_to_temperature_unit_tb.sv
